@@ rtl/core/sbema_pkg.sv @@
// Package for the segmented big-endian memory access unit.
// Holds the beat types, region, size, status and store codes.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package sbema_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int ADDR_W          = 32;
  localparam int DATA_W          = 32;
  localparam int OFS_W           = 20;
  localparam int REGION_W        = 12;
  localparam int STATUS_W        = 3;
  localparam int NUM_STORES      = 3;
  localparam int LANES           = 4;

  localparam logic [REGION_W-1:0] REGION_PROGRAM = 12'h004;
  localparam logic [REGION_W-1:0] REGION_DATA    = 12'h100;
  localparam logic [REGION_W-1:0] REGION_STACK   = 12'h7FF;

  localparam logic [1:0] STORE_PROGRAM = 2'd0;
  localparam logic [1:0] STORE_DATA    = 2'd1;
  localparam logic [1:0] STORE_STACK   = 2'd2;
  localparam logic [1:0] STORE_NONE    = 2'd3;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_REGION  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BEYOND     = 3'd4;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] address;
    logic [1:0]        access_size;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // One classified access as it waits between the front and the back.
  typedef struct packed {
    logic                op;
    logic [1:0]          store;
    logic [1:0]          access_size;
    logic [OFS_W-1:0]    offset;
    logic [DATA_W-1:0]   write_data;
    logic [STATUS_W-1:0] status;
  } work_t;

endpackage

`default_nettype wire

@@ rtl/core/sbema_front.sv @@
// Front end: decodes the region of one request and checks size, alignment and range.
// Depends on sbema_pkg.
`default_nettype none

module sbema_front #(
  parameter int OFFSET_BITS = sbema_pkg::OFFSET_BITS_DEF
) (
  input  sbema_pkg::req_t  req,
  output sbema_pkg::work_t work
);
  import sbema_pkg::*;

  localparam logic [OFS_W-1:0] LOW_MASK =
    OFS_W'((21'(1) << OFFSET_BITS) - 21'(1));

  logic [REGION_W-1:0] region;
  logic [OFS_W-1:0]    offset;
  logic [1:0]          store;
  logic                misaligned;
  logic                beyond;

  assign region = req.address[ADDR_W-1 -: REGION_W];
  assign offset = req.address[OFS_W-1:0];
  assign beyond = |(offset & ~LOW_MASK);

  always_comb begin
    unique case (region)
      REGION_PROGRAM: store = STORE_PROGRAM;
      REGION_DATA:    store = STORE_DATA;
      REGION_STACK:   store = STORE_STACK;
      default:        store = STORE_NONE;
    endcase
  end

  always_comb begin
    unique case (req.access_size)
      SIZE_HALF: misaligned = offset[0];
      SIZE_WORD: misaligned = |offset[1:0];
      default:   misaligned = 1'b0;
    endcase
  end

  always_comb begin
    work.op          = req.op;
    work.store       = store;
    work.access_size = req.access_size;
    work.offset      = offset;
    work.write_data  = req.write_data;
    // The checks are ranked: region, then size, then alignment, then range.
    priority if (store == STORE_NONE) begin
      work.status = ST_NO_REGION;
    end else if (req.access_size == SIZE_BAD) begin
      work.status = ST_BAD_SIZE;
    end else if (misaligned) begin
      work.status = ST_MISALIGNED;
    end else if (beyond) begin
      work.status = ST_BEYOND;
    end else begin
      work.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sbema_queue.sv @@
// Two-entry queue of classified accesses between the front and the back.
// Depends on sbema_pkg.
`default_nettype none

module sbema_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sbema_pkg::work_t push_work,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output sbema_pkg::work_t head_work
);
  import sbema_pkg::*;

  work_t      entries [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_work  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sbema_back.sv @@
// Back end: three byte stores split into four byte lanes each, and the response register.
// Depends on sbema_pkg.
`default_nettype none

module sbema_back #(
  parameter int OFFSET_BITS = sbema_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  sbema_pkg::work_t head_work,
  output logic             pop,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output sbema_pkg::rsp_t  rsp
);
  import sbema_pkg::*;

  localparam int WA_W  = OFFSET_BITS - 2;
  localparam int WORDS = 1 << WA_W;

  logic              out_free;
  logic              s1_free;
  logic              access_ok;
  logic [WA_W-1:0]   waddr;
  logic [LANES-1:0]  lane_en;
  logic [DATA_W-1:0] lane_data;
  logic [7:0]        rd_byte [NUM_STORES][LANES];

  logic              s1_valid;
  logic              s1_read;
  logic [1:0]        s1_store;
  logic [1:0]        s1_size;
  logic [1:0]        s1_lane;
  logic [STATUS_W-1:0] s1_status;

  logic [DATA_W-1:0] word;
  logic [DATA_W-1:0] read_value;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign s1_free   = !s1_valid || out_free;
  assign pop       = head_valid && s1_free;
  assign access_ok = pop && (head_work.status == ST_OK);
  assign waddr     = head_work.offset[OFFSET_BITS-1:2];

  // Lane k holds the bytes whose offset ends in k; lane 0 is the most significant.
  always_comb begin
    unique case (head_work.access_size)
      SIZE_BYTE: lane_en = LANES'(1) << head_work.offset[1:0];
      SIZE_HALF: lane_en = head_work.offset[1] ? 4'b1100 : 4'b0011;
      SIZE_WORD: lane_en = 4'b1111;
      default:   lane_en = 4'b0000;
    endcase
  end

  always_comb begin
    unique case (head_work.access_size)
      SIZE_BYTE: lane_data = {4{head_work.write_data[7:0]}};
      SIZE_HALF: lane_data = {2{head_work.write_data[15:0]}};
      default:   lane_data = head_work.write_data;
    endcase
  end

  for (genvar s = 0; s < NUM_STORES; s++) begin : g_store
    for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic [7:0] mem [WORDS];
      logic [7:0] rd_q;
      logic       sel;

      assign sel = access_ok && (head_work.store == 2'(s));

      always_ff @(posedge clk) begin
        if (sel && head_work.op == OP_WRITE && lane_en[k]) begin
          mem[waddr] <= lane_data[8*(LANES-1-k) +: 8];
        end
        if (sel && head_work.op == OP_READ) begin
          rd_q <= mem[waddr];
        end
      end

      assign rd_byte[s][k] = rd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_read   <= access_ok && (head_work.op == OP_READ);
      s1_store  <= head_work.store;
      s1_size   <= head_work.access_size;
      s1_lane   <= head_work.offset[1:0];
      s1_status <= head_work.status;
    end
  end

  always_comb begin
    unique case (s1_store)
      STORE_PROGRAM: word = {rd_byte[0][0], rd_byte[0][1], rd_byte[0][2], rd_byte[0][3]};
      STORE_DATA:    word = {rd_byte[1][0], rd_byte[1][1], rd_byte[1][2], rd_byte[1][3]};
      STORE_STACK:   word = {rd_byte[2][0], rd_byte[2][1], rd_byte[2][2], rd_byte[2][3]};
      default:       word = '0;
    endcase
  end

  always_comb begin
    if (!s1_read) begin
      read_value = '0;
    end else begin
      unique case (s1_size)
        SIZE_BYTE: begin
          unique case (s1_lane)
            2'd0:    read_value = {24'd0, word[31:24]};
            2'd1:    read_value = {24'd0, word[23:16]};
            2'd2:    read_value = {24'd0, word[15:8]};
            default: read_value = {24'd0, word[7:0]};
          endcase
        end
        SIZE_HALF: read_value = s1_lane[1] ? {16'd0, word[15:0]} : {16'd0, word[31:16]};
        default:   read_value = word;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      rsp.read_data <= read_value;
      rsp.status    <= s1_status;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/segmented_big_endian_memory_access_unit.sv @@
// Segmented big-endian memory port. Each request beat carries one read or write of a
// byte, halfword or word; address bits 31..20 select the program (0x004), data (0x100)
// or stack (0x7FF) store, and the low bits give the byte offset. Every request beat
// yields exactly one response beat with the zero-extended read value and a status:
// ok, no region, bad size, misaligned or offset beyond the store, checked in that
// order. An access with any error changes no store and returns zero data, as does
// every write. The unit takes one request beat per cycle when the response side
// keeps up. A response is offered once its request has passed the front-to-back
// queue, the registered read of the byte-lane memories and the response register.
// The two-entry queue stalls the request side only when full. Store contents are
// undefined after reset until written, and there is no clearing pass.
// Depends on sbema_pkg, sbema_front, sbema_queue and sbema_back.
`default_nettype none

module segmented_big_endian_memory_access_unit #(
  parameter int OFFSET_BITS = sbema_pkg::OFFSET_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  sbema_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output sbema_pkg::rsp_t rsp
);
  import sbema_pkg::*;

  work_t front_work;
  work_t head_work;
  logic  queue_full;
  logic  head_valid;
  logic  pop;
  logic  push;

  // The request side stalls only on a full queue, which is a registered condition.
  assign req_stall = queue_full;
  assign push      = req_valid && !queue_full;

  // Classification is pure logic; its result is written straight into the queue.
  sbema_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .req  (req),
    .work (front_work)
  );

  sbema_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_work  (front_work),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_work  (head_work)
  );

  // The back end pops an entry whenever its pipeline can move, performs the store
  // access and holds the response until the receiver takes it.
  sbema_back #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_work  (head_work),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

@@ rtl/core/sbema_checker.sv @@
// Port-level checker for the segmented big-endian memory access unit, with its bind.
// Depends on sbema_pkg and the top-level module.
`default_nettype none

module sbema_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input sbema_pkg::rsp_t rsp
);
  import sbema_pkg::*;

  // No response beat is left over from before reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response beat changed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_NO_REGION ||
                   rsp.status == ST_MISALIGNED || rsp.status == ST_BAD_SIZE ||
                   rsp.status == ST_BEYOND))
    else $error("response status out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.read_data == '0)
    else $error("error response carries read data");

  // Reset lifts any stall toward the requester.
  a_reset_ready: assert property (@(posedge clk) rst |=> !req_stall)
    else $error("request side stalled right after reset");

endmodule

bind segmented_big_endian_memory_access_unit sbema_checker u_sbema_checker (.*);

`default_nettype wire

@@ tb/sbema_access_checker.sv @@
// Checker for the segmented big-endian memory access unit: watches both channels,
// keeps its own byte image of the three stores and compares every response beat.
// Depends on sbema_pkg for the beat types and the region, size and status codes.
`timescale 1ns / 1ps

module sbema_access_checker
  import sbema_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fails,
  output int   pending
);

  typedef struct {
    req_t access;
    rsp_t answer;
  } awaited_t;

  // Bytes written so far, keyed by full address (region and offset).
  logic [7:0] byte_image [bit [ADDR_W-1:0]];
  awaited_t   awaited_answers [$];

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    fails++;
  endtask

  // Classifies one access in the block's check order and applies it to the image.
  function automatic rsp_t predict_access(input req_t a);
    rsp_t                answer;
    logic [REGION_W-1:0] region;
    logic [OFS_W-1:0]    offset;
    bit [ADDR_W-1:0]     key;
    int                  nbytes;
    answer = '0;
    region = a.address[ADDR_W-1:OFS_W];
    offset = a.address[OFS_W-1:0];
    nbytes = 1 << a.access_size;
    if (region != REGION_PROGRAM && region != REGION_DATA && region != REGION_STACK) begin
      answer.status = ST_NO_REGION;
    end else if (a.access_size == SIZE_BAD) begin
      answer.status = ST_BAD_SIZE;
    end else if ((offset & (nbytes - 1)) != 0) begin
      answer.status = ST_MISALIGNED;
    end else if ((offset >> OFFSET_BITS) != 0) begin
      answer.status = ST_BEYOND;
    end else if (a.op == OP_WRITE) begin
      // Most significant byte goes to the lowest offset.
      for (int i = 0; i < nbytes; i++) begin
        key = a.address + i;
        byte_image[key] = a.write_data[8*(nbytes-1-i) +: 8];
      end
    end else begin
      for (int i = 0; i < nbytes; i++) begin
        key = a.address + i;
        answer.read_data = {answer.read_data[DATA_W-9:0],
                            byte_image.exists(key) ? byte_image[key] : 8'h00};
      end
    end
    return answer;
  endfunction

  always @(posedge clk) begin : watch
    awaited_t due;
    if (rst) begin
      awaited_answers.delete();
      pending <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("response beat %h/%0d with no access outstanding",
                                    rsp.read_data, rsp.status));
        end else begin
          due = awaited_answers.pop_front();
          if (rsp.read_data !== due.answer.read_data) begin
            report_mismatch($sformatf("op %0d addr %h size %0d: read_data %h, expected %h",
                                      due.access.op, due.access.address,
                                      due.access.access_size, rsp.read_data,
                                      due.answer.read_data));
          end
          if (rsp.status !== due.answer.status) begin
            report_mismatch($sformatf("op %0d addr %h size %0d: status %0d, expected %0d",
                                      due.access.op, due.access.address,
                                      due.access.access_size, rsp.status,
                                      due.answer.status));
          end
        end
      end
      if (req_valid && !req_stall) begin
        due.access = req;
        due.answer = predict_access(req);
        awaited_answers.push_back(due);
      end
      pending <= awaited_answers.size();
    end
  end

endmodule

@@ tb/segmented_big_endian_memory_access_unit_test.sv @@
// Top of the testbench for the segmented big-endian memory access unit: clock, reset,
// access stimulus, response-side stalls, a watchdog and the final verdict.
// Depends on sbema_pkg, the unit itself and sbema_access_checker.
`timescale 1ns / 1ps

module segmented_big_endian_memory_access_unit_test;
  import sbema_pkg::*;

  // Last byte offset inside a store, and the offset bits that lie above the store.
  localparam logic [OFS_W-1:0] LAST_OFFSET  = OFS_W'((1 << OFFSET_BITS_DEF) - 1);
  localparam int               SPARE_BITS   = OFS_W - OFFSET_BITS_DEF;
  localparam int               HOLD_CYCLES  = 48;
  localparam int               QUIET_LIMIT  = 4000;
  localparam int               DRAIN_CYCLES = 10;
  localparam int               PHASE_ITEMS  = 150;

  // A span of bytes that has been written successfully; reads are only aimed
  // inside such spans, so no byte is ever read before it was written.
  typedef struct {
    logic [ADDR_W-1:0] address;
    logic [1:0]        size;
  } span_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  int   fails;
  int   pending;

  int    send_idle_pct;
  int    recv_idle_pct;
  int    holds_asked;
  int    holds_done;
  span_t stored_spans [$];

  segmented_big_endian_memory_access_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  sbema_access_checker u_access_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Response side. Normally it stalls at random at the current rate; when a long
  // hold is requested it stalls for a counted stretch so that the unit backs up
  // into its queue and has to stall the request side.
  initial begin
    rsp_stall  = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: a correct unit never goes this long without moving a beat on
  // either channel, even under the long hold.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("segmented_big_endian_memory_access_unit_test NOT OK");
    $finish;
  end

  function automatic req_t access(input logic op, input logic [ADDR_W-1:0] address,
                                  input logic [1:0] size, input logic [DATA_W-1:0] data);
    req_t a;
    a.op          = op;
    a.address     = address;
    a.access_size = size;
    a.write_data  = data;
    return a;
  endfunction

  // A write that the unit will store; the span is remembered for later reads.
  // The caller keeps the offset aligned and inside the store.
  function automatic req_t store_at(input logic [REGION_W-1:0] region, input logic [1:0] size,
                                    input logic [OFS_W-1:0] offset,
                                    input logic [DATA_W-1:0] data);
    span_t span;
    span.address = {region, offset};
    span.size    = size;
    stored_spans.push_back(span);
    return access(OP_WRITE, {region, offset}, size, data);
  endfunction

  function automatic logic [REGION_W-1:0] store_region();
    case ($urandom_range(2))
      0: return REGION_PROGRAM;
      1: return REGION_DATA;
      default: return REGION_STACK;
    endcase
  endfunction

  // Aligned offset inside the store. Half of the offsets crowd into the bottom or
  // the top of the store so that spans overlap and get overwritten often.
  function automatic logic [OFS_W-1:0] store_offset(input logic [1:0] size);
    logic [OFS_W-1:0] ofs;
    case ($urandom_range(3))
      0: ofs = OFS_W'($urandom_range(63));
      1: ofs = LAST_OFFSET - OFS_W'($urandom_range(63));
      default: ofs = OFS_W'($urandom_range(LAST_OFFSET));
    endcase
    return ofs & ~((OFS_W'(1) << size) - OFS_W'(1));
  endfunction

  // Read of a byte, halfword or word that lies inside one written span.
  function automatic req_t read_back();
    span_t      span;
    logic [1:0] size;
    int         pieces;
    span   = stored_spans[$urandom_range(stored_spans.size() - 1)];
    size   = 2'($urandom_range(span.size));
    pieces = (1 << span.size) >> size;
    return access(OP_READ, span.address + ($urandom_range(pieces - 1) << size), size,
                  $urandom);
  endfunction

  // An access that the unit must refuse: unmapped region, bad size, misaligned, or
  // an offset past the end of the store. Reads and writes alike.
  function automatic req_t broken_access();
    logic [REGION_W-1:0] region;
    logic [OFS_W-1:0]    ofs;
    logic [1:0]          size;
    logic [ADDR_W-1:0]   addr;
    region = store_region();
    ofs    = OFS_W'($urandom);
    size   = 2'($urandom_range(SIZE_WORD));
    case ($urandom_range(3))
      0: begin
        // None of the mapped regions has the top address bit set.
        addr = $urandom;
        if (addr[ADDR_W-1:OFS_W] == REGION_PROGRAM || addr[ADDR_W-1:OFS_W] == REGION_DATA ||
            addr[ADDR_W-1:OFS_W] == REGION_STACK) begin
          addr[ADDR_W-1] = 1'b1;
        end
        size = 2'($urandom);
      end
      1: begin
        addr = {region, ofs};
        size = SIZE_BAD;
      end
      2: begin
        size = 2'($urandom_range(SIZE_WORD, SIZE_HALF));
        if (size == SIZE_HALF) begin
          ofs[0] = 1'b1;
        end else begin
          ofs[1:0] = 2'($urandom_range(3, 1));
        end
        addr = {region, ofs};
      end
      default: begin
        ofs = store_offset(size);
        ofs[OFS_W-1:OFFSET_BITS_DEF] = SPARE_BITS'($urandom_range((1 << SPARE_BITS) - 1, 1));
        addr = {region, ofs};
      end
    endcase
    return access(1'($urandom_range(1)), addr, size, $urandom);
  endfunction

  // Offers one request beat, after a random number of idle cycles, and holds it
  // until it is taken. Entered and left at a falling edge.
  task automatic send(input req_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= a;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every outstanding access has been answered.
  task automatic drain();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Random traffic: mostly stored writes and reads of written spans, the rest
  // refused accesses. At item hold_at the response side is told to hold off.
  task automatic run_random(input int count, input int hold_at);
    int         pick;
    logic [1:0] size;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) begin
        holds_asked++;
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        size = 2'($urandom_range(SIZE_WORD));
        send(store_at(store_region(), size, store_offset(size), $urandom));
      end else if (pick < 75) begin
        send(read_back());
      end else begin
        send(broken_access());
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    holds_asked   = 0;
    send_idle_pct = 37;
    recv_idle_pct = 64;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Big-endian layout: one word read back whole, by halves and by a byte.
    send(store_at(REGION_DATA, SIZE_WORD, '0, 32'h1234_5678));
    send(access(OP_READ, {REGION_DATA, 20'h0_0000}, SIZE_WORD, 32'hFFFF_FFFF));
    send(access(OP_READ, {REGION_DATA, 20'h0_0000}, SIZE_HALF, '0));
    send(access(OP_READ, {REGION_DATA, 20'h0_0002}, SIZE_HALF, '0));
    send(access(OP_READ, {REGION_DATA, 20'h0_0003}, SIZE_BYTE, '0));
    // Last byte of the program store; only the low byte of the data is kept.
    send(store_at(REGION_PROGRAM, SIZE_BYTE, LAST_OFFSET, 32'hFFFF_FFAB));
    send(access(OP_READ, {REGION_PROGRAM, LAST_OFFSET}, SIZE_BYTE, '0));
    // Top word of the stack, then its low half overwritten with zeros.
    send(store_at(REGION_STACK, SIZE_WORD, LAST_OFFSET - 20'd3, 32'hFFFF_FFFF));
    send(store_at(REGION_STACK, SIZE_HALF, LAST_OFFSET - 20'd1, 32'hFFFF_0000));
    send(access(OP_READ, {REGION_STACK, LAST_OFFSET - 20'd3}, SIZE_WORD, '0));
    send(access(OP_READ, {REGION_STACK, LAST_OFFSET - 20'd3}, SIZE_BYTE, '0));
    send(store_at(REGION_PROGRAM, SIZE_WORD, '0, '0));
    send(access(OP_READ, {REGION_PROGRAM, 20'h0_0000}, SIZE_WORD, '0));
    // Unmapped regions at both ends of the address space.
    send(access(OP_READ, 32'h0000_0000, SIZE_WORD, '0));
    send(access(OP_WRITE, 32'hFFFF_FFFF, SIZE_BYTE, 32'hFFFF_FFFF));
    // Bad size, misaligned halfword and words, offsets beyond the store.
    send(access(OP_READ, {REGION_DATA, 20'h0_0010}, SIZE_BAD, '0));
    send(access(OP_WRITE, {REGION_STACK, 20'h0_0000}, SIZE_BAD, 32'hDEAD_BEEF));
    send(access(OP_READ, {REGION_DATA, 20'h0_0001}, SIZE_HALF, '0));
    send(access(OP_WRITE, {REGION_DATA, 20'h0_0002}, SIZE_WORD, 32'hCAFE_F00D));
    send(access(OP_READ, {REGION_DATA, 20'h0_0001}, SIZE_WORD, '0));
    send(access(OP_WRITE, {REGION_DATA, 20'h1_0000}, SIZE_WORD, 32'h0BAD_0BAD));
    send(access(OP_READ, {REGION_DATA, 20'hF_FFFF}, SIZE_BYTE, '0));
    // Check order: region before size, size before alignment, alignment before range.
    send(access(OP_READ, 32'h2000_0001, SIZE_BAD, '0));
    send(access(OP_READ, {REGION_STACK, 20'h0_0001}, SIZE_BAD, '0));
    send(access(OP_READ, {REGION_PROGRAM, 20'h1_0001}, SIZE_HALF, '0));

    run_random(PHASE_ITEMS, -1);
    drain();

    send_idle_pct = 64;
    recv_idle_pct = 37;
    run_random(PHASE_ITEMS, -1);
    drain();

    // No idling at all; partway through, the response side holds off while
    // requests keep coming, which fills the queue and stalls the request side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS, 40);
    drain();

    // Give a stray extra response beat time to show up.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0) begin
      $display("segmented_big_endian_memory_access_unit_test OK");
    end else begin
      $display("segmented_big_endian_memory_access_unit_test NOT OK");
    end
    $finish;
  end

endmodule

@@ segmented_big_endian_memory_access_unit.f @@
rtl/core/sbema_pkg.sv
rtl/core/sbema_front.sv
rtl/core/sbema_queue.sv
rtl/core/sbema_back.sv
rtl/core/segmented_big_endian_memory_access_unit.sv
rtl/core/sbema_checker.sv
tb/sbema_access_checker.sv
tb/segmented_big_endian_memory_access_unit_test.sv
